>>> src/hcujt_pkg.sv
package hcujt_pkg;

    typedef struct packed {
        logic              kind;
        logic signed [63:0] host_time;
        logic [47:0]       wall_time;
    } update_t;

    typedef struct packed {
        logic signed [63:0] time_now;
        logic               jump_flag;
        logic [1:0]         unit_state;
    } result_t;

    localparam logic [1:0] UNIT_NONE = 2'd0;
    localparam logic [1:0] UNIT_SEC  = 2'd1;
    localparam logic [1:0] UNIT_MS   = 2'd2;

    localparam logic KIND_UPDATE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOMINAL_FRAME = 1'd1;

    localparam logic [31:0] MAX_FRAME_RESET     = 32'd16384;
    localparam logic [15:0] NOMINAL_FRAME_RESET = 16'd1092;

    localparam logic [2:0]  VOTES_NEEDED   = 3'd4;
    localparam logic [47:0] WALL_MIN_DELTA = 48'd33;
    localparam logic [63:0] MILLI_ROUND    = 64'd500;

    // x / 1000 is (x >> 3) / 125; the divide by 125 uses a 2^-30 scaled reciprocal
    localparam logic [23:0] RECIP_125 = 24'd8589935;
    localparam logic [22:0] DIV_BASE  = 23'd125;

    localparam logic [62:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

endpackage

>>> src/host_clock_unit_and_jump_tracker_core.sv
// Host clock unit detector and jump-free timeline. One request enters per cycle while update_stall
// is low, and its result leaves from a result register that holds while stalled.
// The depth is set by the divide by 1000 for millisecond hosts, done as four 16-bit digit
// steps in successive stages; the unit vote and the timeline update each sit in one stage,
// so back-to-back requests see the state left by the one before. The user must write
// configuration only while no request is in flight; the block itself does not enforce it.
module host_clock_unit_and_jump_tracker_core (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      update_valid,
    output logic                                      update_stall,
    input  hcujt_pkg::update_t                        update_request,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output hcujt_pkg::result_t                        result_request,
    input  logic                                      cfg_write_en,
    input  logic [hcujt_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [hcujt_pkg::CFG_DATA_W-1:0]          cfg_data
);

    typedef struct packed {
        logic [15:0] digit;
        logic [6:0]  rem;
    } div_step_t;

    typedef struct packed {
        logic        kind;
        logic        hv;
        logic [62:0] host;
        logic [47:0] wall;
        logic [60:0] y;
        logic [63:0] quot;
        logic [6:0]  rem;
        logic        vote_ok;
        logic [62:0] hd;
        logic [47:0] wd;
        logic [1:0]  unit;
        logic [62:0] scaled;
    } pipe_t;

    function automatic div_step_t div_step(input logic [6:0] rem_in, input logic [15:0] chunk);
        logic [22:0] v;
        logic [46:0] prod;
        logic [15:0] d;
        logic [22:0] back;
        div_step_t   res;
        v         = {rem_in, chunk};
        prod      = {24'b0, v} * {23'b0, hcujt_pkg::RECIP_125};
        d         = prod[45:30];
        back      = {7'b0, d} * hcujt_pkg::DIV_BASE;
        res.digit = d;
        res.rem   = 7'(v - back);
        return res;
    endfunction

    logic [31:0] max_frame_reg;
    logic [15:0] nominal_frame_reg;

    pipe_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    pipe_t s1_next, s2_next, s3_next, s4_next, s5_next;
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic  adv1, adv2, adv3, adv4, adv5;
    logic  ready1, ready2, ready3, ready4, ready5;
    logic  accept, take_out;

    logic        result_valid_reg;
    hcujt_pkg::result_t result_reg, result_next;

    logic        prev_valid_reg;
    logic [62:0] prev_host_reg;
    logic [47:0] prev_wall_reg;

    logic [2:0]  second_votes_reg, second_votes_next;
    logic [2:0]  milli_votes_reg, milli_votes_next;
    logic [1:0]  unit_code_reg, unit_code_next;

    logic        running_reg, running_next;
    logic [62:0] anchor_reg, anchor_next;
    logic [62:0] offset_reg, offset_next;
    logic [62:0] current_reg, current_next;
    logic [62:0] prev_scaled_reg, prev_scaled_next;

    logic [63:0] round_sum;
    logic [63:0] host_sub;
    logic [48:0] wall_sub;
    div_step_t   step_a, step_b, step_c, step_d;

    logic [66:0] hd_x10;
    logic [51:0] wd_x10;
    logic [54:0] wd_x100;
    logic [61:0] wd_x10000;
    logic        sec_vote, milli_vote, cast;

    logic [63:0] delta;
    logic        jump;
    logic [62:0] elapsed;
    logic [63:0] run_sum, jump_sum;

    // handshake and stage advance
    assign take_out = !result_valid_reg || !result_stall;
    assign adv5     = s5_valid_reg && take_out;
    assign ready5   = !s5_valid_reg || adv5;
    assign adv4     = s4_valid_reg && ready5;
    assign ready4   = !s4_valid_reg || adv4;
    assign adv3     = s3_valid_reg && ready4;
    assign ready3   = !s3_valid_reg || adv3;
    assign adv2     = s2_valid_reg && ready3;
    assign ready2   = !s2_valid_reg || adv2;
    assign adv1     = s1_valid_reg && ready2;
    assign ready1   = !s1_valid_reg || adv1;
    assign accept   = update_valid && ready1;

    assign update_stall   = !ready1;
    assign result_valid   = result_valid_reg;
    assign result_request = result_reg;

    // stage 1 load: rounding add for the millisecond path
    assign round_sum = {1'b0, update_request.host_time[62:0]} + hcujt_pkg::MILLI_ROUND;

    always_comb
    begin
        s1_next      = '0;
        s1_next.kind = update_request.kind;
        s1_next.hv   = !update_request.host_time[63];
        s1_next.host = update_request.host_time[62:0];
        s1_next.wall = update_request.wall_time;
        s1_next.y    = round_sum[63:3];
    end

    // stage 1: deltas and vote gate, first digit
    assign host_sub = {1'b0, s1_reg.host} - {1'b0, prev_host_reg};
    assign wall_sub = {1'b0, s1_reg.wall} - {1'b0, prev_wall_reg};
    assign step_a   = div_step(7'd0, {3'b0, s1_reg.y[60:48]});

    always_comb
    begin
        s2_next             = s1_reg;
        s2_next.hd          = host_sub[62:0];
        s2_next.wd          = wall_sub[47:0];
        s2_next.vote_ok     = (s1_reg.kind == hcujt_pkg::KIND_UPDATE) && s1_reg.hv
                              && prev_valid_reg && !host_sub[63] && (host_sub != 64'd0)
                              && !wall_sub[48] && (wall_sub[47:0] >= hcujt_pkg::WALL_MIN_DELTA);
        s2_next.quot[63:48] = step_a.digit;
        s2_next.rem         = step_a.rem;
    end

    // stage 2: ratio window compares, unit vote and second digit
    assign hd_x10    = {4'b0, s2_reg.hd} * 67'd10;
    assign wd_x10    = {4'b0, s2_reg.wd} * 52'd10;
    assign wd_x100   = {7'b0, s2_reg.wd} * 55'd100;
    assign wd_x10000 = {14'b0, s2_reg.wd} * 62'd10000;
    assign step_b    = div_step(s2_reg.rem, s2_reg.y[47:32]);

    always_comb
    begin
        sec_vote   = (hd_x10 > {19'b0, s2_reg.wd}) && (s2_reg.hd < {11'b0, wd_x10});
        milli_vote = (s2_reg.hd > {8'b0, wd_x100}) && (s2_reg.hd < {1'b0, wd_x10000});
        cast       = s2_reg.vote_ok && (unit_code_reg == hcujt_pkg::UNIT_NONE);

        second_votes_next = second_votes_reg;
        milli_votes_next  = milli_votes_reg;
        unit_code_next    = unit_code_reg;
        if (cast)
        begin
            if (sec_vote)
                second_votes_next = second_votes_reg + 3'd1;
            else if (milli_vote)
                milli_votes_next = milli_votes_reg + 3'd1;
            if (second_votes_next >= hcujt_pkg::VOTES_NEEDED
                || milli_votes_next >= hcujt_pkg::VOTES_NEEDED)
                unit_code_next = (milli_votes_next > second_votes_next)
                                 ? hcujt_pkg::UNIT_MS : hcujt_pkg::UNIT_SEC;
        end

        s3_next             = s2_reg;
        s3_next.unit        = unit_code_next;
        s3_next.quot[47:32] = step_b.digit;
        s3_next.rem         = step_b.rem;
    end

    // stage 3: third digit
    assign step_c = div_step(s3_reg.rem, s3_reg.y[31:16]);

    always_comb
    begin
        s4_next             = s3_reg;
        s4_next.quot[31:16] = step_c.digit;
        s4_next.rem         = step_c.rem;
    end

    // stage 4: last digit and choice of timeline source
    assign step_d = div_step(s4_reg.rem, s4_reg.y[15:0]);

    always_comb
    begin
        s5_next            = s4_reg;
        s5_next.quot[15:0] = step_d.digit;
        s5_next.rem        = step_d.rem;
        s5_next.scaled     = {15'b0, s4_reg.wall};
        if (s4_reg.hv)
        begin
            case (s4_reg.unit)
                hcujt_pkg::UNIT_SEC: s5_next.scaled = s4_reg.host;
                hcujt_pkg::UNIT_MS:  s5_next.scaled = {s4_reg.quot[62:16], step_d.digit};
                default:             s5_next.scaled = {15'b0, s4_reg.wall};
            endcase
        end
    end

    // stage 5: timeline
    assign delta    = {1'b0, s5_reg.scaled} - {1'b0, prev_scaled_reg};
    assign jump     = delta[63] || (delta[62:0] > {31'b0, max_frame_reg});
    assign elapsed  = s5_reg.scaled - anchor_reg;
    assign run_sum  = {1'b0, offset_reg} + {1'b0, elapsed};
    assign jump_sum = {1'b0, current_reg} + {48'b0, nominal_frame_reg};

    always_comb
    begin
        running_next     = running_reg;
        anchor_next      = anchor_reg;
        offset_next      = offset_reg;
        current_next     = current_reg;
        prev_scaled_next = prev_scaled_reg;
        result_next.jump_flag  = 1'b0;
        result_next.unit_state = s5_reg.unit;

        if (s5_reg.kind == hcujt_pkg::KIND_RESTART)
        begin
            running_next = 1'b0;
            anchor_next  = '0;
            offset_next  = '0;
            current_next = '0;
        end
        else if (!running_reg)
        begin
            running_next     = 1'b1;
            anchor_next      = s5_reg.scaled;
            offset_next      = '0;
            current_next     = '0;
            prev_scaled_next = s5_reg.scaled;
        end
        else
        begin
            if (jump)
            begin
                result_next.jump_flag = 1'b1;
                offset_next  = jump_sum[63] ? hcujt_pkg::TIME_MAX : jump_sum[62:0];
                anchor_next  = s5_reg.scaled;
                current_next = offset_next;
            end
            else
            begin
                current_next = run_sum[63] ? hcujt_pkg::TIME_MAX : run_sum[62:0];
            end
            prev_scaled_next = s5_reg.scaled;
        end

        result_next.time_now = {1'b0, current_next};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg     <= hcujt_pkg::MAX_FRAME_RESET;
            nominal_frame_reg <= hcujt_pkg::NOMINAL_FRAME_RESET;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            s4_valid_reg      <= 1'b0;
            s5_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            prev_valid_reg    <= 1'b0;
            second_votes_reg  <= '0;
            milli_votes_reg   <= '0;
            unit_code_reg     <= hcujt_pkg::UNIT_NONE;
            running_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    hcujt_pkg::CFG_MAX_FRAME:     max_frame_reg     <= cfg_data;
                    hcujt_pkg::CFG_NOMINAL_FRAME: nominal_frame_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            s1_valid_reg     <= accept || (s1_valid_reg && !adv1);
            s2_valid_reg     <= adv1 || (s2_valid_reg && !adv2);
            s3_valid_reg     <= adv2 || (s3_valid_reg && !adv3);
            s4_valid_reg     <= adv3 || (s4_valid_reg && !adv4);
            s5_valid_reg     <= adv4 || (s5_valid_reg && !adv5);
            result_valid_reg <= adv5 || (result_valid_reg && result_stall);
            if (adv1 && s1_reg.kind == hcujt_pkg::KIND_UPDATE && s1_reg.hv)
                prev_valid_reg <= 1'b1;
            if (adv2)
            begin
                second_votes_reg <= second_votes_next;
                milli_votes_reg  <= milli_votes_next;
                unit_code_reg    <= unit_code_next;
            end
            if (adv5)
                running_reg <= running_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (adv1)
            s2_reg <= s2_next;
        if (adv2)
            s3_reg <= s3_next;
        if (adv3)
            s4_reg <= s4_next;
        if (adv4)
            s5_reg <= s5_next;
        if (adv1 && s1_reg.kind == hcujt_pkg::KIND_UPDATE && s1_reg.hv)
        begin
            prev_host_reg <= s1_reg.host;
            prev_wall_reg <= s1_reg.wall;
        end
        if (adv5)
        begin
            result_reg      <= result_next;
            anchor_reg      <= anchor_next;
            offset_reg      <= offset_next;
            current_reg     <= current_next;
            prev_scaled_reg <= prev_scaled_next;
        end
    end

    // once settled the unit never changes
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_code_reg != hcujt_pkg::UNIT_NONE |=> $stable(unit_code_reg))
        else $error("unit changed after settling");

    // a settled unit needs a full count of votes on one side
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_code_reg != hcujt_pkg::UNIT_NONE |->
            (second_votes_reg >= hcujt_pkg::VOTES_NEEDED
             || milli_votes_reg >= hcujt_pkg::VOTES_NEEDED))
        else $error("unit settled without enough votes");

    // vote counts stop at the settle threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        second_votes_reg <= hcujt_pkg::VOTES_NEEDED
        && milli_votes_reg <= hcujt_pkg::VOTES_NEEDED)
        else $error("vote count past threshold");

    // the timeline is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !result_reg.time_now[63])
        else $error("negative timeline value");

endmodule
